// ----- src/bst_pkg.sv -----
// Shared types, constants and helpers for the byte stream tokenizer.
// No dependencies; imported by every module of the block.
`default_nettype none

package bst_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int FIFO_DEPTH  = 4;

    localparam logic [2:0] KIND_IDENT = 3'd0;
    localparam logic [2:0] KIND_INT   = 3'd1;
    localparam logic [2:0] KIND_NUM   = 3'd2;
    localparam logic [2:0] KIND_CHAR  = 3'd3;
    localparam logic [2:0] KIND_END   = 3'd4;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_ASCII_MAX = 8'd127;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  char_code;
        logic [23:0] start_offset;
        logic [23:0] token_length;
        logic [15:0] token_line;
        logic        last_of_run;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  char_code;
        logic [23:0] start_offset;
        logic [23:0] token_length;
        logic [15:0] token_line;
    } tok_t;

    // up to three tokens caused by one byte
    typedef struct packed {
        logic [1:0]     count;
        tok_t [2:0]     tok;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    function automatic logic [23:0] to_out24(input logic [OFFSET_BITS-1:0] v);
        logic [OFFSET_BITS+23:0] wide;
        wide = {24'd0, v};
        return wide[23:0];
    endfunction

    function automatic tok_t make_tok(input logic [2:0] kind, input logic [7:0] code,
                                      input logic [OFFSET_BITS-1:0] start,
                                      input logic [OFFSET_BITS-1:0] len,
                                      input logic [15:0] line);
        tok_t t;
        t.token_kind   = kind;
        t.char_code    = code;
        t.start_offset = to_out24(start);
        t.token_length = to_out24(len);
        t.token_line   = line;
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- src/bst_front.sv -----
// Front end: classifies each accepted byte, tracks scan state, offsets and lines,
// and builds the bundle of tokens that byte causes. Depends on bst_pkg.
`default_nettype none

module bst_front
    import bst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire in_item_t    in_item,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata,
    output logic             bun_valid,
    output bundle_t          bun
);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_IDENT = 3'd1;
    localparam logic [2:0] MODE_INT   = 3'd2;
    localparam logic [2:0] MODE_NUM   = 3'd3;
    localparam logic [2:0] MODE_MINUS = 3'd4;
    localparam logic [2:0] MODE_CR    = 3'd5;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};
    localparam logic [OFFSET_BITS-1:0] ONE_LEN = {{(OFFSET_BITS-1){1'b0}}, 1'b1};

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_id_start(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A))
            || (c > CH_ASCII_MAX);
    endfunction

    function automatic logic has_token(input logic [2:0] m);
        return (m == MODE_IDENT) || (m == MODE_INT) || (m == MODE_NUM) || (m == MODE_MINUS);
    endfunction

    function automatic logic [2:0] kind_of(input logic [2:0] m);
        logic [2:0] k;
        case (m)
            MODE_IDENT: k = KIND_IDENT;
            MODE_INT:   k = KIND_INT;
            MODE_NUM:   k = KIND_NUM;
            default:    k = KIND_CHAR;
        endcase
        return k;
    endfunction

    logic [2:0]             mode_reg,   mode_next;
    logic [OFFSET_BITS-1:0] tstart_reg, tstart_next;
    logic [OFFSET_BITS-1:0] pos_reg,    pos_next;
    logic [15:0]            line_reg,   line_next;
    logic [15:0]            first_line_reg, first_line_next;

    logic [7:0]             b;
    logic [OFFSET_BITS-1:0] cur, nxt;
    logic                   do_close, do_begin, emit_char;
    logic [2:0]             mode1;
    logic [OFFSET_BITS-1:0] tstart1;
    logic [15:0]            line1, line_inc;
    tok_t                   close_tok, char_tok, close2_tok, end_tok;
    logic [1:0]             n;

    always_comb
    begin
        b        = in_item.data_byte;
        cur      = pos_reg;
        nxt      = (pos_reg == POS_MAX) ? pos_reg : pos_reg + ONE_LEN;
        line_inc = (line_reg == 16'hFFFF) ? line_reg : line_reg + 16'd1;
        do_close  = 1'b0;
        do_begin  = 1'b0;
        emit_char = 1'b0;
        mode1     = mode_reg;
        tstart1   = tstart_reg;
        line1     = line_reg;

        case (mode_reg)
            MODE_IDENT:
            begin
                if (!(is_id_start(b) || is_digit(b) || b == CH_UNDER))
                begin
                    do_close = 1'b1;
                    do_begin = 1'b1;
                end
            end
            MODE_INT:
            begin
                if (b == CH_DOT)
                    mode1 = MODE_NUM;
                else if (!is_digit(b))
                begin
                    do_close = 1'b1;
                    do_begin = 1'b1;
                end
            end
            MODE_NUM:
            begin
                if (!is_digit(b))
                begin
                    do_close = 1'b1;
                    do_begin = 1'b1;
                end
            end
            MODE_MINUS:
            begin
                if (is_digit(b))
                    mode1 = MODE_INT;
                else
                begin
                    do_close = 1'b1;
                    do_begin = 1'b1;
                end
            end
            MODE_CR:
            begin
                mode1    = MODE_IDLE;
                do_begin = (b != CH_LF);
            end
            default:
            begin
                do_begin = 1'b1;
            end
        endcase

        if (do_begin)
        begin
            mode1 = MODE_IDLE;
            if (b == CH_SPACE || b == CH_TAB)
                mode1 = MODE_IDLE;
            else if (b == CH_LF)
                line1 = line_inc;
            else if (b == CH_CR)
            begin
                line1 = line_inc;
                mode1 = MODE_CR;
            end
            else if (is_digit(b))
            begin
                tstart1 = cur;
                mode1   = MODE_INT;
            end
            else if (b == CH_MINUS)
            begin
                tstart1 = cur;
                mode1   = MODE_MINUS;
            end
            else if (is_id_start(b))
            begin
                tstart1 = cur;
                mode1   = MODE_IDENT;
            end
            else
                emit_char = 1'b1;
        end

        close_tok = make_tok(kind_of(mode_reg),
                             (mode_reg == MODE_MINUS) ? CH_MINUS : 8'd0, tstart_reg,
                             (mode_reg == MODE_MINUS) ? ONE_LEN : cur - tstart_reg,
                             line_reg);
        char_tok   = make_tok(KIND_CHAR, b, cur, ONE_LEN, line_reg);
        close2_tok = make_tok(kind_of(mode1), (mode1 == MODE_MINUS) ? CH_MINUS : 8'd0,
                              tstart1, (mode1 == MODE_MINUS) ? ONE_LEN : nxt - tstart1,
                              line1);
        end_tok    = make_tok(KIND_END, 8'd0, nxt, '0, line1);

        n   = 2'd0;
        bun = '0;
        if (do_close)
        begin
            bun.tok[n] = close_tok;
            n = n + 2'd1;
        end
        if (emit_char)
        begin
            bun.tok[n] = char_tok;
            n = n + 2'd1;
        end
        if (in_item.is_last && has_token(mode1))
        begin
            bun.tok[n] = close2_tok;
            n = n + 2'd1;
        end
        if (in_item.is_last)
        begin
            bun.tok[n] = end_tok;
            n = n + 2'd1;
        end
        bun.count = n;
        bun_valid = accept && (n != 2'd0);

        mode_next       = mode_reg;
        tstart_next     = tstart_reg;
        pos_next        = pos_reg;
        line_next       = line_reg;
        first_line_next = cfg_we ? cfg_wdata : first_line_reg;

        if (accept)
        begin
            if (in_item.is_last)
            begin
                mode_next   = MODE_IDLE;
                tstart_next = '0;
                pos_next    = '0;
                line_next   = first_line_reg;
            end
            else
            begin
                mode_next   = mode1;
                tstart_next = tstart1;
                pos_next    = nxt;
                line_next   = line1;
            end
        end
        else if (cfg_we && pos_reg == '0 && mode_reg == MODE_IDLE)
            line_next = cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_IDLE;
            tstart_reg     <= '0;
            pos_reg        <= '0;
            line_reg       <= 16'd1;
            first_line_reg <= 16'd1;
        end
        else
        begin
            mode_reg       <= mode_next;
            tstart_reg     <= tstart_next;
            pos_reg        <= pos_next;
            line_reg       <= line_next;
            first_line_reg <= first_line_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bst_fifo.sv -----
// Short queue of token bundles between the front end and the output stage.
// Depends on bst_pkg.
`default_nettype none

module bst_fifo
    import bst_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire bundle_t wr_data,
    input  wire logic    rd_en,
    output bundle_t      rd_data,
    output fifo_stat_t   stat
);

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

    bundle_t          mem_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg,    cnt_next;
    logic             do_wr, do_rd;

    assign stat.full  = (cnt_reg == CNT_FULL);
    assign stat.empty = (cnt_reg == '0);
    assign rd_data    = mem_reg[rd_ptr_reg];
    assign do_wr      = wr_en && !stat.full;
    assign do_rd      = rd_en && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_rd)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_wr && !do_rd)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (do_rd && !do_wr)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

// ----- src/bst_back.sv -----
// Output stage: unpacks queued bundles one token per transfer into an output
// register and marks the last token of each byte. Depends on bst_pkg.
`default_nettype none

module bst_back
    import bst_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire fifo_stat_t q_stat,
    input  wire bundle_t    q_head,
    output logic            q_pop,
    input  wire logic       pop,
    output logic            empty,
    output out_item_t       out_item
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg,   idx_next;
    out_item_t  out_reg;
    logic       load, is_end;
    tok_t       sel;

    assign empty    = !valid_reg;
    assign out_item = out_reg;
    assign load     = !q_stat.empty && (!valid_reg || pop);
    assign sel      = q_head.tok[idx_reg];
    assign is_end   = (idx_reg == q_head.count - 2'd1);
    assign q_pop    = load && is_end;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = is_end ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            out_reg <= {sel, is_end};
    end

endmodule

`default_nettype wire

// ----- src/byte_stream_tokenizer_top.sv -----
// Byte stream tokenizer, top level: front end, bundle queue and output stage.
// Depends on bst_pkg, bst_front, bst_fifo, bst_back.
//
// Usage:
//   Input is a queue write port: a byte transfers on a clock edge with push high
//   and full low. in_item.is_last marks the final byte of a text buffer.
//   Results are a queue read port: the oldest token sits on out_item while
//   empty is low and transfers on an edge with pop high.
//   Each byte yields zero to three tokens; the last token of a byte carries
//   last_of_run. The final byte of a buffer closes any open token and adds an
//   end token, after which offsets and the line count restart.
//   Path: a byte's tokens are written into the bundle queue, then loaded into the output register.
//   Throughput: one byte per cycle while each byte yields at most one token;
//   the output stage moves one token per cycle while pop is high, and a four-bundle
//   queue between the front end and the output stage absorbs bursts.
//   When the receiver stalls, the queue fills and full rises; nothing is lost.
//   cfg_we/cfg_wdata write the first line number; write only while idle.
//   Reset empties the queue, clears scan state and sets the first line to 1.
`default_nettype none

module byte_stream_tokenizer_top
    import bst_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire in_item_t    in_item,
    output logic             empty,
    input  wire logic        pop,
    output out_item_t        out_item,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_wdata
);

    logic       accept;
    logic       bun_valid;
    bundle_t    bun;
    bundle_t    q_head;
    logic       q_pop;
    fifo_stat_t q_stat;

    assign full   = q_stat.full;
    assign accept = push && !q_stat.full;

    bst_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .bun_valid (bun_valid),
        .bun       (bun)
    );

    bst_fifo u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (bun_valid),
        .wr_data (bun),
        .rd_en   (q_pop),
        .rd_data (q_head),
        .stat    (q_stat)
    );

    bst_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_stat   (q_stat),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(bun_valid && q_stat.full))
        else $error("bundle written into a full queue");

    a_end_token: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.token_kind == KIND_END) |->
            (out_item.token_length == 24'd0 && out_item.last_of_run))
        else $error("end token malformed");

    a_char_len: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_item.token_kind == KIND_CHAR) |-> (out_item.token_length == 24'd1))
        else $error("single character token length not one");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_item)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- bench/byte_stream_tokenizer_top_tb.sv -----
// Self-checking bench for byte_stream_tokenizer_top: feeds text buffers byte by byte,
// predicts the token stream in a lexer model of its own and compares every transfer.
// Depends on bst_pkg and the RTL of the block only.
module byte_stream_tokenizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bst_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_IDENT,
        SCAN_INT,
        SCAN_NUM,
        SCAN_MINUS,
        SCAN_CR
    } scan_mode_e;

    localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] ONE_LEN = OFFSET_BITS'(1);
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int RUN_BYTES = 44;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    in_item_t    in_item = '0;
    logic        empty;
    logic        pop = 1'b0;
    out_item_t   out_item;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;

    in_item_t  text_bytes[$];
    out_item_t tokens_due[$];
    out_item_t byte_tokens[$];

    scan_mode_e             lex_mode;
    logic [OFFSET_BITS-1:0] lex_tok_start;
    logic [OFFSET_BITS-1:0] lex_pos;
    logic [15:0]            lex_line;
    logic [15:0]            lex_first_line;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    bit rx_hold_on = 1'b0;
    int rx_hold_cnt = 0;
    int n_errors = 0;

    byte_stream_tokenizer_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_item  (in_item),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic bit is_digit(input logic [7:0] b);
        return b >= CH_DIGIT_0 && b <= CH_DIGIT_0 + 8'd9;
    endfunction

    function automatic bit is_ident_head(input logic [7:0] b);
        return (b >= CH_LOWER_A && b <= CH_LOWER_A + 8'd25)
            || (b >= CH_UPPER_A && b <= CH_UPPER_A + 8'd25)
            || b > CH_ASCII_MAX;
    endfunction

    function automatic bit is_ident_tail(input logic [7:0] b);
        return is_ident_head(b) || is_digit(b) || b == CH_UNDER;
    endfunction

    task automatic emit_token(input logic [2:0] kind, input logic [7:0] code,
                              input logic [OFFSET_BITS-1:0] start,
                              input logic [OFFSET_BITS-1:0] len);
        out_item_t t;
        t.token_kind   = kind;
        t.char_code    = code;
        t.start_offset = start;
        t.token_length = len;
        t.token_line   = lex_line;
        t.last_of_run  = 1'b0;
        byte_tokens.push_back(t);
    endtask

    task automatic bump_line();
        if (lex_line != 16'hFFFF)
            lex_line = lex_line + 16'd1;
    endtask

    // flush the open token (or held minus) that ends just before endp
    task automatic close_token(input logic [OFFSET_BITS-1:0] endp);
        logic [OFFSET_BITS-1:0] len;
        len = (endp >= lex_tok_start) ? endp - lex_tok_start : '0;
        case (lex_mode)
            SCAN_IDENT: emit_token(KIND_IDENT, 8'd0, lex_tok_start, len);
            SCAN_INT:   emit_token(KIND_INT, 8'd0, lex_tok_start, len);
            SCAN_NUM:   emit_token(KIND_NUM, 8'd0, lex_tok_start, len);
            SCAN_MINUS: emit_token(KIND_CHAR, CH_MINUS, lex_tok_start, ONE_LEN);
            default: ;
        endcase
        lex_mode = SCAN_IDLE;
    endtask

    task automatic open_by_byte(input logic [7:0] b, input logic [OFFSET_BITS-1:0] cur);
        if (b == CH_SPACE || b == CH_TAB)
        begin
            lex_mode = SCAN_IDLE;
        end
        else if (b == CH_LF)
        begin
            bump_line();
            lex_mode = SCAN_IDLE;
        end
        else if (b == CH_CR)
        begin
            bump_line();
            lex_mode = SCAN_CR;
        end
        else if (is_digit(b))
        begin
            lex_tok_start = cur;
            lex_mode = SCAN_INT;
        end
        else if (b == CH_MINUS)
        begin
            lex_tok_start = cur;
            lex_mode = SCAN_MINUS;
        end
        else if (is_ident_head(b))
        begin
            lex_tok_start = cur;
            lex_mode = SCAN_IDENT;
        end
        else
        begin
            emit_token(KIND_CHAR, b, cur, ONE_LEN);
            lex_mode = SCAN_IDLE;
        end
    endtask

    task automatic lex_reset();
        lex_first_line = 16'd1;
        lex_mode = SCAN_IDLE;
        lex_tok_start = '0;
        lex_pos = '0;
        lex_line = lex_first_line;
    endtask

    task automatic lex_set_first_line(input logic [15:0] v);
        lex_first_line = v;
        if (lex_pos == '0 && lex_mode == SCAN_IDLE)
            lex_line = v;
    endtask

    task automatic lex_byte(input in_item_t it);
        logic [7:0]             b;
        logic [OFFSET_BITS-1:0] cur;
        logic [OFFSET_BITS-1:0] nxt;
        out_item_t              t;
        b = it.data_byte;
        cur = lex_pos;
        nxt = (cur != POS_MAX) ? cur + 1'b1 : cur;
        byte_tokens.delete();
        case (lex_mode)
            SCAN_IDENT:
                if (!is_ident_tail(b))
                begin
                    close_token(cur);
                    open_by_byte(b, cur);
                end
            SCAN_INT:
                if (b == CH_DOT)
                    lex_mode = SCAN_NUM;
                else if (!is_digit(b))
                begin
                    close_token(cur);
                    open_by_byte(b, cur);
                end
            SCAN_NUM:
                if (!is_digit(b))
                begin
                    close_token(cur);
                    open_by_byte(b, cur);
                end
            SCAN_MINUS:
                if (is_digit(b))
                    lex_mode = SCAN_INT;
                else
                begin
                    close_token(cur);
                    open_by_byte(b, cur);
                end
            SCAN_CR:
            begin
                lex_mode = SCAN_IDLE;
                if (b != CH_LF)
                    open_by_byte(b, cur);
            end
            default:
            begin
                lex_mode = SCAN_IDLE;
                open_by_byte(b, cur);
            end
        endcase
        lex_pos = nxt;
        if (it.is_last)
        begin
            close_token(nxt);
            emit_token(KIND_END, 8'd0, nxt, '0);
            lex_mode = SCAN_IDLE;
            lex_tok_start = '0;
            lex_pos = '0;
            lex_line = lex_first_line;
        end
        if (byte_tokens.size() != 0)
        begin
            t = byte_tokens[$];
            t.last_of_run = 1'b1;
            byte_tokens[byte_tokens.size() - 1] = t;
        end
        foreach (byte_tokens[i])
            tokens_due.push_back(byte_tokens[i]);
    endtask

    task automatic check_token(input out_item_t got);
        out_item_t want;
        if (tokens_due.size() == 0)
        begin
            $error("token with none expected: kind %0d offset %0d",
                   got.token_kind, got.start_offset);
            n_errors++;
        end
        else
        begin
            want = tokens_due.pop_front();
            if (got.token_kind !== want.token_kind)
            begin
                $error("token_kind: expected %0d, got %0d", want.token_kind, got.token_kind);
                n_errors++;
            end
            if (got.char_code !== want.char_code)
            begin
                $error("char_code: expected %0d, got %0d", want.char_code, got.char_code);
                n_errors++;
            end
            if (got.start_offset !== want.start_offset)
            begin
                $error("start_offset: expected %0d, got %0d",
                       want.start_offset, got.start_offset);
                n_errors++;
            end
            if (got.token_length !== want.token_length)
            begin
                $error("token_length: expected %0d, got %0d",
                       want.token_length, got.token_length);
                n_errors++;
            end
            if (got.token_line !== want.token_line)
            begin
                $error("token_line: expected %0d, got %0d",
                       want.token_line, got.token_line);
                n_errors++;
            end
            if (got.last_of_run !== want.last_of_run)
            begin
                $error("last_of_run: expected %0d, got %0d",
                       want.last_of_run, got.last_of_run);
                n_errors++;
            end
        end
    endtask

    // driver: register writes and byte transfers land in the model at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push <= 1'b0;
            in_item <= '0;
            lex_reset();
        end
        else
        begin
            if (cfg_we)
                lex_set_first_line(cfg_wdata);
            if (push && !full)
            begin
                lex_byte(in_item);
                void'(text_bytes.pop_front());
            end
            if (!(push && full))
            begin
                if (text_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    push <= 1'b1;
                    in_item <= text_bytes[0];
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: checks each transfer and drives pop with random stalls and hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
                check_token(out_item);
            if (rx_hold_on && rx_hold_cnt < RX_HOLD_CYCLES)
            begin
                rx_hold_cnt = rx_hold_cnt + 1;
                pop <= 1'b0;
            end
            else
            begin
                pop <= ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    task automatic queue_byte(input logic [7:0] b);
        in_item_t it;
        it.data_byte = b;
        it.is_last = 1'b0;
        text_bytes.push_back(it);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endtask

    task automatic end_buffer();
        in_item_t it;
        it = text_bytes[$];
        it.is_last = 1'b1;
        text_bytes[text_bytes.size() - 1] = it;
    endtask

    function automatic logic [7:0] rand_digit();
        return CH_DIGIT_0 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_ident_byte(input bit head);
        case ($urandom_range(0, head ? 2 : 4))
            0: return CH_LOWER_A + 8'($urandom_range(0, 25));
            1: return CH_UPPER_A + 8'($urandom_range(0, 25));
            2: return 8'($urandom_range(128, 255));
            3: return rand_digit();
            default: return CH_UNDER;
        endcase
    endfunction

    // mostly well-formed tokens with random content, some raw noise bytes
    task automatic queue_random_buffer();
        int n_tok;
        n_tok = $urandom_range(1, 8);
        for (int k = 0; k < n_tok; k++)
        begin
            case ($urandom_range(0, 11))
                0, 1:
                begin
                    queue_byte(rand_ident_byte(1'b1));
                    repeat ($urandom_range(0, 5)) queue_byte(rand_ident_byte(1'b0));
                end
                2:
                begin
                    if ($urandom_range(0, 1))
                        queue_byte(CH_MINUS);
                    repeat ($urandom_range(1, 4)) queue_byte(rand_digit());
                end
                3:
                begin
                    repeat ($urandom_range(1, 3)) queue_byte(rand_digit());
                    queue_byte(CH_DOT);
                    repeat ($urandom_range(0, 3)) queue_byte(rand_digit());
                    if ($urandom_range(0, 3) == 0)
                        queue_byte(CH_DOT);
                end
                4: queue_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
                5:
                    case ($urandom_range(0, 2))
                        0: queue_byte(CH_LF);
                        1: queue_byte(CH_CR);
                        default:
                        begin
                            queue_byte(CH_CR);
                            queue_byte(CH_LF);
                        end
                    endcase
                6: queue_byte(CH_MINUS);
                7: queue_byte(CH_DOT);
                8, 9: queue_byte(8'($urandom_range(0, 255)));
                default: queue_byte(8'($urandom_range(8'h21, 8'h2F)));
            endcase
            if ($urandom_range(0, 2) == 0)
                queue_byte(CH_SPACE);
        end
        end_buffer();
    endtask

    task automatic wait_drained();
        while (text_bytes.size() != 0 || tokens_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_first_line(input logic [15:0] v);
        wait_drained();
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int tx_pct, input int rx_pct, input int n_bytes);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        @(negedge clk);
        while (text_bytes.size() < n_bytes)
            queue_random_buffer();
        wait_drained();
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed buffers, first line still at its reset value
        @(negedge clk);
        queue_text("x");
        queue_byte(8'hFF);
        queue_text("_9 -7.5.");
        queue_byte(CH_TAB);
        queue_text("-a");
        queue_byte(CH_CR);
        queue_byte(CH_LF);
        queue_text("0");
        queue_byte(CH_CR);
        queue_byte(CH_ASCII_MAX);
        queue_byte(CH_LF);
        queue_byte(8'h00);
        end_buffer();
        queue_text("-");
        end_buffer();
        queue_text("7");
        queue_byte(CH_CR);
        end_buffer();
        wait_drained();

        write_first_line(16'hFFFF);
        run_random(0, 0, RUN_BYTES);

        write_first_line(16'h0000);
        tx_idle_pct = 56;
        rx_stall_pct = 0;
        @(negedge clk);
        while (text_bytes.size() < RUN_BYTES)
            queue_random_buffer();
        // leave a buffer open so the next write lands mid-buffer
        queue_text("ab");
        wait_drained();

        write_first_line(16'($urandom_range(0, 65535)));
        run_random(0, 56, RUN_BYTES);

        write_first_line(16'hFFFE);
        run_random(32, 32, RUN_BYTES);

        write_first_line(16'($urandom_range(0, 65535)));
        rx_hold_on = 1'b1;
        run_random(0, 0, RUN_BYTES);
        rx_hold_on = 1'b0;

        wait_drained();
        if (n_errors == 0 && tokens_due.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
